>>> hw/rtl/tbd_pkg.sv
// thermal brightness derating: shared constants and step tables
// no dependencies; used by thermal_brightness_derating

package tbd_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int LEVEL_W    = 8;
    localparam int STEP_COUNT = 5;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [LEVEL_W-1:0]  level_t;

    typedef sample_t threshold_table_t [STEP_COUNT];
    typedef level_t  level_table_t [STEP_COUNT];

    localparam level_t LEVEL_RESET = 8'hff;

    localparam threshold_table_t RISE_THRESHOLD = '{
        10'h1e5, 10'h1df, 10'h1d1, 10'h1c4, 10'h1b7
    };

    localparam threshold_table_t FALL_THRESHOLD = '{
        10'h3ff, 10'h1d1, 10'h1c4, 10'h1b7, 10'h1aa
    };

    localparam level_table_t STEP_LEVEL = '{
        8'hff, 8'hb4, 8'h80, 8'h5a, 8'h40
    };

endpackage

>>> hw/rtl/thermal_brightness_derating.sv
// a transferred sample is registered in stage one, then in the result register, which drives out_valid
// throughput: one sample per cycle; only a stalled result register holds the input back
// stage one updates the window and running sum, stage two divides, compares and steps
// the level; the result register doubles as the previous-average and level state
// reset (async, rst_n low): window, sum, slot and previous average clear to zero,
// brightness level goes to full scale (0xff), both stages empty

module thermal_brightness_derating #(
    parameter int AVG_DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [tbd_pkg::SAMPLE_W-1:0] adc_sample,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tbd_pkg::SAMPLE_W-1:0] filtered_temp,
    output logic [tbd_pkg::LEVEL_W-1:0]  brightness_level,
    output logic                      level_changed
);

    // width of the slot index and of the running sum
    localparam int SLOT_W = $clog2(AVG_DEPTH);
    localparam int SUM_W  = tbd_pkg::SAMPLE_W + SLOT_W;

    // exact floor division by AVG_DEPTH: multiply by a rounded-up reciprocal,
    // shift by the sum width plus the log of the depth
    localparam int DIV_SHIFT = SUM_W + SLOT_W;
    localparam int RECIP_INT = ((2 ** DIV_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [SUM_W:0] RECIP = RECIP_INT[SUM_W:0];
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);
    localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(AVG_DEPTH * 1023);

    // ------------------------------------------------------------------
    // stage one: sample window and running sum
    // ------------------------------------------------------------------
    tbd_pkg::sample_t    window_reg [AVG_DEPTH];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                s1_valid_reg;

    // stage two / result register, which also holds previous average and level
    tbd_pkg::sample_t    avg_reg;
    tbd_pkg::level_t     level_reg;
    logic                changed_reg;
    logic                out_valid_reg;

    logic                in_xfer;
    logic                out_load;

    // result register takes a new value from a full stage one when it is empty or being drained
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    // stage one can refill when empty or when its content moves on this cycle
    assign in_ready = !s1_valid_reg || out_load;
    assign in_xfer  = in_valid && in_ready;

    // oldest sample leaves the sum, the new one enters
    assign sum_next  = sum_reg + SUM_W'(adc_sample) - SUM_W'(window_reg[slot_reg]);
    assign slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
            slot_reg     <= '0;
            sum_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                window_reg[slot_reg] <= adc_sample;
                slot_reg             <= slot_next;
                sum_reg              <= sum_next;
            end
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage two: average, threshold scan, level step
    // ------------------------------------------------------------------
    logic [2*SUM_W:0]    div_product;
    tbd_pkg::sample_t    avg_next;
    tbd_pkg::level_t     level_next;
    logic                changed_next;

    assign div_product = (2*SUM_W+1)'(sum_reg) * (2*SUM_W+1)'(RECIP);
    assign avg_next    = div_product[DIV_SHIFT +: tbd_pkg::SAMPLE_W];

    always_comb
    begin
        logic found;
        found      = 1'b0;
        level_next = level_reg;
        if (avg_next > avg_reg)
        begin
            // rising: first step from the hottest threshold down that lifts the level
            for (int k = 0; k < tbd_pkg::STEP_COUNT; k++)
            begin
                if (!found && avg_next > tbd_pkg::RISE_THRESHOLD[k]
                    && level_reg < tbd_pkg::STEP_LEVEL[k])
                begin
                    level_next = tbd_pkg::STEP_LEVEL[k];
                    found      = 1'b1;
                end
            end
        end
        else if (avg_next < avg_reg)
        begin
            // falling: scan from the lowest level up, take first that lowers the level
            for (int k = tbd_pkg::STEP_COUNT - 1; k >= 0; k--)
            begin
                if (!found && avg_next < tbd_pkg::FALL_THRESHOLD[k]
                    && level_reg > tbd_pkg::STEP_LEVEL[k])
                begin
                    level_next = tbd_pkg::STEP_LEVEL[k];
                    found      = 1'b1;
                end
            end
        end
        changed_next = (level_next != level_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg       <= '0;
            level_reg     <= tbd_pkg::LEVEL_RESET;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                avg_reg     <= avg_next;
                level_reg   <= level_next;
                changed_reg <= changed_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign filtered_temp    = avg_reg;
    assign brightness_level = level_reg;
    assign level_changed    = changed_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // level only ever takes one of the table levels
    a_level_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg == tbd_pkg::STEP_LEVEL[0] || level_reg == tbd_pkg::STEP_LEVEL[1]
        || level_reg == tbd_pkg::STEP_LEVEL[2] || level_reg == tbd_pkg::STEP_LEVEL[3]
        || level_reg == tbd_pkg::STEP_LEVEL[4])
        else $error("brightness level left the step table");

    // running sum never exceeds a full window of maximum samples
    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("running sum out of range");

    // a result appears only after stage one held an item
    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a stage one item");

    // level state moves only when a result is loaded
    a_level_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(level_reg))
        else $error("level changed without a result load");

    // a raised level needs a rising average
    a_raise_needs_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && level_next > level_reg) |-> (avg_next > avg_reg))
        else $error("level raised while average did not rise");

endmodule
